// ===== src/mva_pkg.sv =====
// ----------------------------------------------------------------------------
// mva_pkg
// shared types, constants and the note period lookup for the voice allocator
// ----------------------------------------------------------------------------
package mva_pkg;

  localparam int DEF_VOICE_COUNT  = 4;
  localparam int MAX_RESULTS      = 4;
  localparam int NOTE_TOP         = 108;
  localparam int TOP_PERIOD       = 149;
  localparam int STEPS_PER_OCTAVE = 12;
  localparam int BEND_DIVISOR     = 16;
  localparam int BEND_CENTER      = 32;

  localparam logic [7:0] HIGH_NIBBLE   = 8'hF0;
  localparam logic [7:0] NOTE_ON_CODE  = 8'h90;
  localparam logic [7:0] NOTE_OFF_CODE = 8'h80;
  localparam logic [7:0] BEND_CODE     = 8'hE0;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_BITS    = 50;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

  // operation codes of a voice scan
  localparam logic [1:0] OP_RELEASE = 2'd0;
  localparam logic [1:0] OP_STRIKE  = 2'd1;
  localparam logic [1:0] OP_BEND    = 2'd2;

  typedef struct packed {
    logic [15:0] bend;
    logic [15:0] period;
    logic [7:0]  velocity;
    logic [7:0]  note;
  } voice_t;

  typedef struct packed {
    logic [15:0] bend_offset;
    logic [15:0] period;
    logic [7:0]  velocity;
    logic [7:0]  note_number;
    logic [1:0]  voice_index;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  note;
    logic [7:0]  velocity;
    logic [15:0] period;
    logic [5:0]  amount;
  } bend_req_t;

  function automatic logic [8:0] period_base(input logic [3:0] i);
    logic [8:0] v;
    unique case (i)
      4'd0:    v = 9'd158;
      4'd1:    v = 9'd168;
      4'd2:    v = 9'd178;
      4'd3:    v = 9'd188;
      4'd4:    v = 9'd199;
      4'd5:    v = 9'd211;
      4'd6:    v = 9'd224;
      4'd7:    v = 9'd237;
      4'd8:    v = 9'd251;
      4'd9:    v = 9'd266;
      4'd10:   v = 9'd282;
      default: v = 9'd299;
    endcase
    return v;
  endfunction

  // octave by reciprocal multiply, exact for distances up to 107
  function automatic logic [15:0] period_of(input logic [7:0] n);
    logic [6:0]  x;
    logic [14:0] prod;
    logic [3:0]  oct;
    logic [6:0]  rem;
    logic [23:0] sh;
    if (n >= 8'(NOTE_TOP)) begin
      return 16'(TOP_PERIOD);
    end
    x    = 7'(NOTE_TOP - 1 - int'(n));
    prod = 15'(x) * 15'd171;
    oct  = prod[14:11];
    rem  = 7'(x - 7'(oct) * 7'(STEPS_PER_OCTAVE));
    sh   = 24'(period_base(rem[3:0])) << oct;
    return sh[15:0];
  endfunction

endpackage

// ===== src/mva_bend_unit.sv =====
// ----------------------------------------------------------------------------
// mva_bend_unit
// three-stage pipe computing one voice's pitch bend offset
// ----------------------------------------------------------------------------
module mva_bend_unit import mva_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  bend_req_t   req,
  output logic        done,
  output logic [15:0] offset
);

  logic        s1_valid;
  logic        s2_valid;
  logic        s3_valid;
  logic [15:0] s1_next;
  logic [15:0] s1_period;
  logic        s1_below;
  logic        s1_zero;
  logic [5:0]  s1_amount;
  logic signed [12:0] s2_q;
  logic [5:0]  s2_k;
  logic        s2_below;
  logic        s2_zero;
  logic [16:0] d;
  logic [16:0] d_adj;
  logic signed [19:0] prod;
  logic [7:0]  nbr;
  logic        below;

  assign below = req.amount < 6'(BEND_CENTER);
  assign nbr   = below ? req.note - 8'd1 : req.note + 8'd1;

  always_comb begin
    d     = s1_below ? {1'b0, s1_next} - {1'b0, s1_period}
                     : {1'b0, s1_period} - {1'b0, s1_next};
    // truncate toward zero
    d_adj = d + {13'd0, {4{d[16]}}};
    prod  = 20'(s2_q) * 20'(signed'({1'b0, s2_k}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_next   <= period_of(nbr);
      s1_period <= req.period;
      s1_below  <= below;
      s1_zero   <= (req.velocity == 8'd0) || (req.amount == 6'(BEND_CENTER));
      s1_amount <= req.amount;
    end
    if (s1_valid) begin
      s2_q     <= signed'(d_adj[16:4]);
      s2_k     <= s1_below ? 6'(BEND_CENTER) - s1_amount : s1_amount - 6'(BEND_CENTER);
      s2_below <= s1_below;
      s2_zero  <= s1_zero;
    end
    if (s2_valid) begin
      if (s2_zero) begin
        offset <= 16'd0;
      end else if (s2_below) begin
        offset <= prod[15:0];
      end else begin
        offset <= 16'd0 - prod[15:0];
      end
    end
  end

  assign done = s3_valid;

endmodule

// ===== src/midi_voice_allocator_top.sv =====
// ----------------------------------------------------------------------------
// midi_voice_allocator_top
// MIDI byte parser and polyphonic voice allocator with per-voice updates
// ----------------------------------------------------------------------------
// Takes one MIDI byte per input beat and reports each voice that the byte
// changes, up to MAX_RESULTS of them, as one output beat each, tlast on the
// final one. Status bytes and data bytes that do not finish a message are
// taken without a voice scan. A byte that finishes a note-on or note-off scans
// the voice memory through its single port, with a read, evaluate and
// write-back step per voice visited. A byte that finishes a pitch bend adds
// the three-stage bend pipe to each visit. Input is taken only between scans;
// a finished beat may still wait in the output register.
module midi_voice_allocator_top import mva_pkg::*; #(
  parameter int VOICE_COUNT = DEF_VOICE_COUNT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // midi_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // voice_index, note_number, velocity, period, bend_offset, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast    // last
);

  localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VOICE_COUNT - 1);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_ON_KEY   = 3'd1;
  localparam logic [2:0] PH_OFF_KEY  = 3'd2;
  localparam logic [2:0] PH_ON_VEL   = 3'd3;
  localparam logic [2:0] PH_BEND_LSB = 3'd4;
  localparam logic [2:0] PH_BEND_MSB = 3'd5;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_BEND  = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [2:0]       phase;
  logic [7:0]       pending_note;
  logic [5:0]       bend_amount;
  logic [1:0]       op;
  logic [7:0]       key;
  logic [7:0]       strike_vel;
  logic [15:0]      strike_period;
  logic [IDX_W-1:0] idx;
  logic [2:0]       cnt;

  voice_t           mem [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] mem_valid;
  voice_t           rdata;
  logic             rd_valid;
  voice_t           voice;
  voice_t           newv;

  logic             held_valid;
  out_beat_t        held;
  logic             out_valid;
  out_beat_t        out_beat;
  logic             out_last;

  logic             accept;
  logic [7:0]       b;
  logic [7:0]       hi;
  logic             start_scan;
  logic [1:0]       start_op;
  logic [7:0]       start_key;

  logic             upd;
  logic             emit;
  logic             out_free;
  logic             stall;
  logic             done_scan;
  logic             wr_en;
  logic             out_load;
  logic             out_load_last;
  out_beat_t        out_load_beat;
  out_beat_t        new_beat;

  bend_req_t        bend_req;
  logic             bend_start;
  logic             bend_done;
  logic [15:0]      bend_nb;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign hi            = b & HIGH_NIBBLE;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_beat};
  assign m_axis_tlast  = out_last;
  assign out_free      = !out_valid || m_axis_tready;

  // parser: decides whether this beat starts a voice scan
  always_comb begin
    start_scan = 1'b0;
    start_op   = OP_RELEASE;
    start_key  = b;
    if (hi != NOTE_ON_CODE && hi != NOTE_OFF_CODE && hi != BEND_CODE) begin
      unique case (phase)
        PH_OFF_KEY: begin
          start_scan = 1'b1;
        end
        PH_ON_VEL: begin
          start_scan = 1'b1;
          start_key  = pending_note;
          start_op   = (b == 8'd0) ? OP_RELEASE : OP_STRIKE;
        end
        PH_BEND_MSB: begin
          start_scan = 1'b1;
          start_op   = OP_BEND;
        end
        default: begin
          start_scan = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pending_note <= 8'd0;
      bend_amount  <= 6'd0;
    end else if (accept) begin
      if (hi == NOTE_ON_CODE) begin
        phase <= PH_ON_KEY;
      end else if (hi == NOTE_OFF_CODE) begin
        phase <= PH_OFF_KEY;
      end else if (hi == BEND_CODE) begin
        phase <= PH_BEND_LSB;
      end else begin
        unique case (phase)
          PH_ON_KEY: begin
            pending_note <= b;
            phase        <= PH_ON_VEL;
          end
          PH_OFF_KEY, PH_ON_VEL: begin
            phase <= PH_IDLE;
          end
          PH_BEND_LSB: begin
            phase <= PH_BEND_MSB;
          end
          PH_BEND_MSB: begin
            bend_amount <= b[6:1];
            phase       <= PH_IDLE;
          end
          default: begin
            phase <= phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && start_scan) begin
      op            <= start_op;
      key           <= start_key;
      strike_vel    <= b;
      strike_period <= period_of(pending_note);
    end
  end

  // voice memory
  assign voice = rd_valid ? rdata : '0;

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rdata <= mem[idx];
    end
    if (wr_en) begin
      mem[idx] <= newv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (state == S_READ) begin
        rd_valid <= mem_valid[idx];
      end
      if (wr_en) begin
        mem_valid[idx] <= 1'b1;
      end
    end
  end

  assign bend_req   = '{note: voice.note, velocity: voice.velocity,
                        period: voice.period, amount: bend_amount};
  assign bend_start = (state == S_EVAL) && (op == OP_BEND);

  mva_bend_unit u_bend (
    .clk    (clk),
    .rst    (rst),
    .start  (bend_start),
    .req    (bend_req),
    .done   (bend_done),
    .offset (bend_nb)
  );

  // update of one voice
  always_comb begin
    newv = voice;
    upd  = 1'b0;
    unique case (op)
      OP_STRIKE: begin
        upd           = (voice.note == 8'd0) || (voice.note == key);
        newv.note     = key;
        newv.velocity = strike_vel;
        newv.period   = strike_period;
      end
      OP_BEND: begin
        upd       = (bend_nb != voice.bend);
        newv.bend = bend_nb;
      end
      default: begin
        upd           = (voice.note == key);
        newv.note     = 8'd0;
        newv.velocity = 8'd0;
      end
    endcase
    new_beat = '{bend_offset: newv.bend, period: newv.period, velocity: newv.velocity,
                 note_number: newv.note, voice_index: 2'(idx)};
    emit      = upd && (cnt < 3'(MAX_RESULTS));
    stall     = emit && held_valid && !out_free;
    done_scan = ((op == OP_STRIKE) && upd) || (idx == IDX_LAST);
    wr_en     = (state == S_APPLY) && !stall && upd;

    out_load      = 1'b0;
    out_load_last = 1'b0;
    out_load_beat = held;
    if (state == S_APPLY && emit && held_valid && !stall) begin
      out_load = 1'b1;
    end
    if (state == S_FLUSH && held_valid && out_free) begin
      out_load      = 1'b1;
      out_load_last = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  state_next = (accept && start_scan) ? S_READ : S_IDLE;
      S_READ:  state_next = S_EVAL;
      S_EVAL:  state_next = (op == OP_BEND) ? S_BEND : S_APPLY;
      S_BEND:  state_next = bend_done ? S_APPLY : S_BEND;
      S_APPLY: begin
        if (stall) begin
          state_next = S_APPLY;
        end else begin
          state_next = done_scan ? S_FLUSH : S_READ;
        end
      end
      S_FLUSH: state_next = (!held_valid || out_free) ? S_IDLE : S_FLUSH;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      cnt        <= 3'd0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && start_scan) begin
        idx <= '0;
        cnt <= 3'd0;
      end
      if (state == S_APPLY && !stall) begin
        if (!done_scan) begin
          idx <= idx + 1'b1;
        end
        if (emit) begin
          held_valid <= 1'b1;
          cnt        <= cnt + 3'd1;
        end
      end
      if (state == S_FLUSH && out_free) begin
        held_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY && emit && !stall) begin
      held <= new_beat;
    end
    if (out_load) begin
      out_beat <= out_load_beat;
      out_last <= out_load_last;
    end
  end

endmodule

// ===== src/mva_checker.sv =====
// ----------------------------------------------------------------------------
// mva_port_checks
// port-level checks for the voice allocator, bound to the top level
// ----------------------------------------------------------------------------
module mva_port_checks import mva_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output beat right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:OUT_BITS] == '0))
    else $error("output pad bits not zero");

  a_no_input_mid_burst: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken before the burst of a byte ended");

endmodule

bind midi_voice_allocator_top mva_port_checks u_mva_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
